FILE: design/complex_arithmetic_unit_macros.svh
// ============================================================================
// Complex arithmetic unit assertion macros
// Shared property shorthands for the checker of the complex arithmetic unit.
// Each macro expects signals named clk and rst_n in the using scope.
// ============================================================================
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CAU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex arithmetic unit assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CAU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("complex arithmetic unit assertion failed");

`endif

FILE: design/cau_pkg.sv
// ============================================================================
// Complex arithmetic unit package
// Word format, opcodes, status codes and the iteration stage record.
// ============================================================================
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int W2        = 2 * WORD_BITS;
  localparam int CW        = WORD_BITS + 2;
  localparam int STEPS     = WORD_BITS;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MAG  = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef logic signed [W2-1:0] prod_t;
  typedef logic signed [W2:0]   sum_t;
  typedef logic signed [CW-1:0] clip_t;

  // One stage of the shared divide / square root iteration chain.
  typedef struct packed {
    op_t                    op;
    logic                   neg_re;
    logic                   neg_im;
    logic                   dz;
    logic                   ovf_re;
    logic                   ovf_im;
    logic [W2-1:0]          den;
    logic [W2-1:0]          dr_re;
    logic [WORD_BITS-1:0]   dq_re;
    logic [W2-1:0]          dr_im;
    logic [WORD_BITS-1:0]   dq_im;
    logic [WORD_BITS+1:0]   sr;
    logic [WORD_BITS-1:0]   sq;
    logic [W2-1:0]          sx;
    clip_t                  pre_re;
    clip_t                  pre_im;
  } it_t;

endpackage

FILE: design/complex_arithmetic_unit.sv
// ============================================================================
// Complex arithmetic unit
// Throughput: one transaction per cycle while no result waits on a stalled
// output; the divide and square root chains retire one quotient or root
// bit per stage, WORD_BITS stages deep.
// Reset: synchronous active-low rst_n clears all valid bits; payload is not reset.
// ============================================================================
module complex_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_opcode,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_real,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_imag,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_real,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_imag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_real,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_imag,
  output logic [1:0]                          out_status
);
  import cau_pkg::*;

  // Pipeline overview. Stage 1 forms the eight 32x32 products and the linear
  // results (add, subtract, conjugate). Stage 2 sums products into the
  // numerators, the divisor c*c+d*d and the magnitude radicand a*a+b*b.
  // Stage 3 takes magnitudes, rounds the multiply result and seeds the two
  // restoring dividers and the digit-by-digit square root. WORD_BITS
  // iteration stages follow, each resolving one quotient bit for both parts
  // and one root bit. The output stage rounds, applies signs and saturates.
  // The whole pipe advances together; it only halts when a finished result
  // waits on a stalled output, so no transaction is lost or repeated.

  localparam logic [W2:0] HALF  = (W2+1)'(1) << (FRAC_BITS - 1);
  localparam logic [W2:0] CLAMP = (W2+1)'(1) << WORD_BITS;
  localparam int          NW    = W2 + FRAC_BITS;
  localparam int          DW    = W2 + WORD_BITS;
  localparam clip_t       MAXC  = clip_t'({2'b00, 1'b0, {(WORD_BITS-1){1'b1}}});
  localparam clip_t       MINC  = clip_t'({2'b11, 1'b1, {(WORD_BITS-1){1'b0}}});

  logic advance;

  // Stage 1 registers.
  logic  s1_vld_r;
  op_t   s1_op_r, s1_op_nxt;
  clip_t s1_lre_r, s1_lim_r, s1_lre_nxt, s1_lim_nxt;
  prod_t s1_ac_r, s1_bd_r, s1_bc_r, s1_ad_r, s1_cc_r, s1_dd_r, s1_aa_r, s1_bb_r;

  // Stage 2 registers.
  logic          s2_vld_r;
  op_t           s2_op_r;
  clip_t         s2_lre_r, s2_lim_r;
  sum_t          s2_nre_r, s2_nim_r, s2_nre_nxt, s2_nim_nxt;
  logic [W2-1:0] s2_den_r, s2_sq_r;

  // Iteration chain; index 0 is the stage 3 register.
  it_t  it_r   [0:STEPS];
  it_t  it_nxt [0:STEPS];
  logic it_vld_r [0:STEPS];

  // Output registers.
  logic                        out_valid_r;
  logic signed [WORD_BITS-1:0] out_re_r, out_im_r, out_re_nxt, out_im_nxt;
  logic [1:0]                  out_st_r, out_st_nxt;

  assign in_stall     = out_valid_r & out_stall;
  assign advance      = ~in_stall;
  assign out_valid    = out_valid_r;
  assign out_res_real = out_re_r;
  assign out_res_imag = out_im_r;
  assign out_status   = out_st_r;

  function automatic logic [W2-1:0] mag_of(input sum_t v);
    logic [W2:0] t;
    t = v[W2] ? -v : v;
    return t[W2-1:0];
  endfunction

  // Round half away from zero, then pre-clamp so the value fits clip_t.
  function automatic clip_t mul_round(input logic neg, input logic [W2-1:0] m);
    logic [W2:0]        s;
    logic [W2:0]        r;
    logic [WORD_BITS:0] c;
    s = {1'b0, m} + HALF;
    r = s >> FRAC_BITS;
    c = (r > CLAMP) ? CLAMP[WORD_BITS:0] : r[WORD_BITS:0];
    return neg ? -clip_t'({1'b0, c}) : clip_t'({1'b0, c});
  endfunction

  // One restoring divide step for each part and one square root step.
  function automatic it_t step(input it_t s);
    it_t                  n;
    logic [W2:0]          tre, tim, dn;
    logic [WORD_BITS+3:0] ts, tt;
    logic                 bre, bim, bs;
    n   = s;
    dn  = {1'b0, s.den};
    tre = {s.dr_re, s.dq_re[WORD_BITS-1]};
    tim = {s.dr_im, s.dq_im[WORD_BITS-1]};
    bre = tre >= dn;
    bim = tim >= dn;
    n.dr_re = W2'(bre ? tre - dn : tre);
    n.dr_im = W2'(bim ? tim - dn : tim);
    n.dq_re = {s.dq_re[WORD_BITS-2:0], bre};
    n.dq_im = {s.dq_im[WORD_BITS-2:0], bim};
    ts = {s.sr, s.sx[W2-1 -: 2]};
    tt = (WORD_BITS+4)'({s.sq, 2'b01});
    bs = ts >= tt;
    n.sr = (WORD_BITS+2)'(bs ? ts - tt : ts);
    n.sq = {s.sq[WORD_BITS-2:0], bs};
    n.sx = {s.sx[W2-3:0], 2'b00};
    return n;
  endfunction

  function automatic clip_t div_result(input logic ovf, input logic neg,
                                       input logic [WORD_BITS-1:0] q,
                                       input logic [W2-1:0] r,
                                       input logic [W2-1:0] den);
    logic [WORD_BITS:0] qr;
    if (ovf) begin
      qr = CLAMP[WORD_BITS:0];
    end else begin
      qr = {1'b0, q} + (WORD_BITS+1)'({r, 1'b0} >= {1'b0, den});
    end
    return neg ? -clip_t'({1'b0, qr}) : clip_t'({1'b0, qr});
  endfunction

  // Returns the saturation flag above the clamped word.
  function automatic logic [WORD_BITS:0] clamp(input clip_t v);
    if (v > MAXC) begin
      return {1'b1, MAXC[WORD_BITS-1:0]};
    end else if (v < MINC) begin
      return {1'b1, MINC[WORD_BITS-1:0]};
    end
    return {1'b0, v[WORD_BITS-1:0]};
  endfunction

  // --------------------------------------------------------------------------
  // Stage 1: opcode decode, linear operations and the eight products.
  // --------------------------------------------------------------------------
  always_comb begin
    s1_op_nxt  = op_t'(in_opcode);
    s1_lre_nxt = '0;
    s1_lim_nxt = '0;
    case (s1_op_nxt)
      OP_ADD: begin
        s1_lre_nxt = clip_t'(in_a_real) + clip_t'(in_b_real);
        s1_lim_nxt = clip_t'(in_a_imag) + clip_t'(in_b_imag);
      end
      OP_SUB: begin
        s1_lre_nxt = clip_t'(in_a_real) - clip_t'(in_b_real);
        s1_lim_nxt = clip_t'(in_a_imag) - clip_t'(in_b_imag);
      end
      OP_CONJ: begin
        s1_lre_nxt = clip_t'(in_a_real);
        s1_lim_nxt = -clip_t'(in_a_imag);
      end
      default: begin
        s1_lre_nxt = '0;
        s1_lim_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r  <= s1_op_nxt;
      s1_lre_r <= s1_lre_nxt;
      s1_lim_r <= s1_lim_nxt;
      s1_ac_r  <= prod_t'(in_a_real) * prod_t'(in_b_real);
      s1_bd_r  <= prod_t'(in_a_imag) * prod_t'(in_b_imag);
      s1_bc_r  <= prod_t'(in_a_imag) * prod_t'(in_b_real);
      s1_ad_r  <= prod_t'(in_a_real) * prod_t'(in_b_imag);
      s1_cc_r  <= prod_t'(in_b_real) * prod_t'(in_b_real);
      s1_dd_r  <= prod_t'(in_b_imag) * prod_t'(in_b_imag);
      s1_aa_r  <= prod_t'(in_a_real) * prod_t'(in_a_real);
      s1_bb_r  <= prod_t'(in_a_imag) * prod_t'(in_a_imag);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: numerator, divisor and radicand sums.
  // --------------------------------------------------------------------------
  always_comb begin
    if (s1_op_r == OP_DIV) begin
      s2_nre_nxt = sum_t'(s1_ac_r) + sum_t'(s1_bd_r);
      s2_nim_nxt = sum_t'(s1_bc_r) - sum_t'(s1_ad_r);
    end else begin
      s2_nre_nxt = sum_t'(s1_ac_r) - sum_t'(s1_bd_r);
      s2_nim_nxt = sum_t'(s1_bc_r) + sum_t'(s1_ad_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op_r  <= s1_op_r;
      s2_lre_r <= s1_lre_r;
      s2_lim_r <= s1_lim_r;
      s2_nre_r <= s2_nre_nxt;
      s2_nim_r <= s2_nim_nxt;
      // Squares are never negative, so their bits add as unsigned values.
      s2_den_r <= s1_cc_r[W2-1:0] + s1_dd_r[W2-1:0];
      s2_sq_r  <= s1_aa_r[W2-1:0] + s1_bb_r[W2-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 and iteration chain.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [W2-1:0] mre, mim;
    logic [NW-1:0] nre, nim;
    logic [DW-1:0] dsh;
    mre = mag_of(s2_nre_r);
    mim = mag_of(s2_nim_r);
    nre = {mre, {FRAC_BITS{1'b0}}};
    nim = {mim, {FRAC_BITS{1'b0}}};
    dsh = {s2_den_r, {WORD_BITS{1'b0}}};

    it_nxt[0].op     = s2_op_r;
    it_nxt[0].neg_re = s2_nre_r[W2];
    it_nxt[0].neg_im = s2_nim_r[W2];
    it_nxt[0].dz     = (s2_den_r == '0);
    // A quotient of 2^WORD_BITS or more saturates whatever its sign.
    it_nxt[0].ovf_re = DW'(nre) >= dsh;
    it_nxt[0].ovf_im = DW'(nim) >= dsh;
    it_nxt[0].den    = s2_den_r;
    it_nxt[0].dr_re  = W2'(nre[NW-1:WORD_BITS]);
    it_nxt[0].dq_re  = nre[WORD_BITS-1:0];
    it_nxt[0].dr_im  = W2'(nim[NW-1:WORD_BITS]);
    it_nxt[0].dq_im  = nim[WORD_BITS-1:0];
    it_nxt[0].sr     = '0;
    it_nxt[0].sq     = '0;
    it_nxt[0].sx     = s2_sq_r;
    if (s2_op_r == OP_MUL) begin
      it_nxt[0].pre_re = mul_round(s2_nre_r[W2], mre);
      it_nxt[0].pre_im = mul_round(s2_nim_r[W2], mim);
    end else begin
      it_nxt[0].pre_re = s2_lre_r;
      it_nxt[0].pre_im = s2_lim_r;
    end

    for (int k = 1; k <= STEPS; k++) begin
      it_nxt[k] = step(it_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k <= STEPS; k++) begin
        it_r[k] <= it_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: final rounding, sign, saturation and status.
  // --------------------------------------------------------------------------
  always_comb begin
    clip_t              vre, vim;
    logic [WORD_BITS:0] cre, cim;
    logic [WORD_BITS:0] qq;
    logic               dz;
    vre = '0;
    vim = '0;
    dz  = 1'b0;
    qq  = {1'b0, it_r[STEPS].sq} +
          (WORD_BITS+1)'(it_r[STEPS].sr > (WORD_BITS+2)'(it_r[STEPS].sq));
    case (it_r[STEPS].op)
      OP_ADD, OP_SUB, OP_CONJ, OP_MUL: begin
        vre = it_r[STEPS].pre_re;
        vim = it_r[STEPS].pre_im;
      end
      OP_DIV: begin
        if (it_r[STEPS].dz) begin
          dz = 1'b1;
        end else begin
          vre = div_result(it_r[STEPS].ovf_re, it_r[STEPS].neg_re, it_r[STEPS].dq_re,
                           it_r[STEPS].dr_re, it_r[STEPS].den);
          vim = div_result(it_r[STEPS].ovf_im, it_r[STEPS].neg_im, it_r[STEPS].dq_im,
                           it_r[STEPS].dr_im, it_r[STEPS].den);
        end
      end
      OP_MAG: begin
        vre = clip_t'({1'b0, qq});
      end
      default: begin
        vre = '0;
        vim = '0;
      end
    endcase
    cre        = clamp(vre);
    cim        = clamp(vim);
    out_re_nxt = cre[WORD_BITS-1:0];
    out_im_nxt = cim[WORD_BITS-1:0];
    if (dz) begin
      out_st_nxt = ST_DZ;
    end else if (cre[WORD_BITS] | cim[WORD_BITS]) begin
      out_st_nxt = ST_SAT;
    end else begin
      out_st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_re_r <= out_re_nxt;
      out_im_r <= out_im_nxt;
      out_st_r <= out_st_nxt;
    end
  end

  // Valid bits travel with each transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= STEPS; k++) begin
        it_vld_r[k] <= 1'b0;
      end
    end else if (advance) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      it_vld_r[0] <= s2_vld_r;
      for (int k = 1; k <= STEPS; k++) begin
        it_vld_r[k] <= it_vld_r[k-1];
      end
      out_valid_r <= it_vld_r[STEPS];
    end
  end

endmodule

FILE: design/cau_checker.sv
// ============================================================================
// Complex arithmetic unit checker
// Port-level properties of the complex arithmetic unit, bound to the top level.
// ============================================================================
`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [2:0]                          in_opcode,
  input logic signed [cau_pkg::WORD_BITS-1:0] in_a_real,
  input logic signed [cau_pkg::WORD_BITS-1:0] in_a_imag,
  input logic signed [cau_pkg::WORD_BITS-1:0] in_b_real,
  input logic signed [cau_pkg::WORD_BITS-1:0] in_b_imag,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [cau_pkg::WORD_BITS-1:0] out_res_real,
  input logic signed [cau_pkg::WORD_BITS-1:0] out_res_imag,
  input logic [1:0]                          out_status
);
  import cau_pkg::*;

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // A stalled result transaction holds its payload.
  `CAU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_res_real) && $stable(out_res_imag) && $stable(out_status))

  // The input side is only held back by a result waiting on a stalled output.
  `CAU_ASSERT_IMP(a_in_stall_cause, in_stall, out_valid && out_stall)

  // Divide by zero returns zero in both parts.
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_status == ST_DZ, out_res_real == '0 && out_res_imag == '0)

  // A saturated result has at least one part pinned at a range limit.
  `CAU_ASSERT_IMP(a_sat_limit, out_valid && out_status == ST_SAT, out_res_real == WMAX || out_res_real == WMIN || out_res_imag == WMAX || out_res_imag == WMIN)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

FILE: sim/complex_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Runs a table of directed operand sets, then about a thousand random
// transactions, through the valid/stall channels. Random bursts and gaps on
// the input side and a shifting stall pattern on the output side exercise
// the handshake. One long output hold-off fills the pipeline. Each result is
// compared field by field with a typed result or a fixed-point predictor of the unit.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  // The two opcode values that the unit does not define. They must give
  // zero results with an ok status.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 1080;
  localparam int IDLE_LIMIT   = 4000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 3 * (WORD_BITS + 3);
  localparam int HOLD_CYCLES  = 300;   // long output hold-off
  localparam int HOLD_AT      = 400;   // input transactions before the hold-off

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [WORD_BITS-1:0] re;
    logic signed [WORD_BITS-1:0] im;
    logic [1:0]                  st;
  } cplx_res_t;

  typedef struct {
    logic [2:0]                  op;
    logic signed [WORD_BITS-1:0] ar, ai, br, bi;
    bit                          typed;
    logic signed [WORD_BITS-1:0] re, im;
    logic [1:0]                  st;
  } vector_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [2:0]                  in_opcode;
  logic signed [WORD_BITS-1:0] in_a_real, in_a_imag, in_b_real, in_b_imag;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [WORD_BITS-1:0] out_res_real, out_res_imag;
  logic [1:0]                  out_status;

  cplx_res_t pending_results[$];
  int        errors    = 0;
  int        accepted  = 0;
  int        idle_cnt  = 0;

  complex_arithmetic_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor. Everything is carried in 128-bit signed values, so the exact
  // products and sums never wrap; rounding is half away from zero on the
  // magnitude, and each part is clamped to the word range at the end.
  // --------------------------------------------------------------------------
  function automatic logic signed [WORD_BITS-1:0] clamp_word(wide_t v, inout bit sat);
    wide_t hi_lim, lo_lim;
    hi_lim = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo_lim = -(wide_t'(1) <<< (WORD_BITS - 1));
    if (v > hi_lim) begin
      sat = 1'b1;
      return hi_lim[WORD_BITS-1:0];
    end
    if (v < lo_lim) begin
      sat = 1'b1;
      return lo_lim[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic wide_t round_shift(wide_t v);
    logic [127:0] mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (v < 0) ? -wide_t'(mag) : wide_t'(mag);
  endfunction

  function automatic wide_t round_div(wide_t num, logic [127:0] den);
    logic [127:0] mag, quo, rem;
    mag = (num < 0) ? -num : num;
    mag = mag << FRAC_BITS;
    quo = mag / den;
    rem = mag % den;
    if ((rem << 1) >= den) quo = quo + 1;
    return (num < 0) ? -wide_t'(quo) : wide_t'(quo);
  endfunction

  function automatic wide_t root_nearest(logic [127:0] x);
    logic [127:0] q, t;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      t = q | (128'd1 << i);
      if (t * t <= x) q = t;
    end
    if (x - q * q > q) q = q + 1;
    return wide_t'(q);
  endfunction

  function automatic cplx_res_t predict_cplx(logic [2:0] op,
                                             logic signed [WORD_BITS-1:0] ar, ai, br, bi);
    wide_t        a, b, c, d, re, im;
    logic [127:0] den;
    bit           sat;
    bit           dz;
    cplx_res_t    r;
    a = ar;
    b = ai;
    c = br;
    d = bi;
    re = '0;
    im = '0;
    sat = 1'b0;
    dz = 1'b0;
    case (op_t'(op))
      OP_ADD: begin
        re = a + c;
        im = b + d;
      end
      OP_SUB: begin
        re = a - c;
        im = b - d;
      end
      OP_MUL: begin
        re = round_shift(a * c - b * d);
        im = round_shift(b * c + a * d);
      end
      OP_DIV: begin
        den = c * c + d * d;
        if (den == 0) begin
          dz = 1'b1;
        end else begin
          re = round_div(a * c + b * d, den);
          im = round_div(b * c - a * d, den);
        end
      end
      OP_CONJ: begin
        re = a;
        im = -b;
      end
      OP_MAG: begin
        re = root_nearest(a * a + b * b);
      end
      default: ;
    endcase
    r.re = clamp_word(re, sat);
    r.im = clamp_word(im, sat);
    r.st = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Fields change at the falling edge; a transaction completes
  // at the rising edge where valid is high and stall is low. The expected
  // result is queued at that moment, so the queue follows input order.
  // --------------------------------------------------------------------------
  task automatic send_item(vector_t v);
    cplx_res_t expected;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_opcode <= v.op;
    in_a_real <= v.ar;
    in_a_imag <= v.ai;
    in_b_real <= v.br;
    in_b_imag <= v.bi;
    do @(posedge clk); while (in_stall);
    if (v.typed) begin
      expected.re = v.re;
      expected.im = v.im;
      expected.st = v.st;
    end else begin
      expected = predict_cplx(v.op, v.ar, v.ai, v.br, v.bi);
    end
    pending_results.push_back(expected);
    accepted++;
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Operands mix full-range words with small values, exact extremes and
  // mid-sized values, so both saturation and normal rounding get traffic.
  function automatic logic signed [WORD_BITS-1:0] pick_operand();
    logic signed [WORD_BITS-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = 32'h0001_0000;
        endcase
      end
      default: v = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
    endcase
    return v;
  endfunction

  function automatic vector_t random_item();
    vector_t v;
    v.op = $urandom_range(0, 7);
    v.ar = pick_operand();
    v.ai = pick_operand();
    v.br = pick_operand();
    v.bi = pick_operand();
    // A share of the divides get a zero divisor.
    if (v.op == OP_DIV && $urandom_range(0, 9) == 0) begin
      v.br = '0;
      v.bi = '0;
    end
    v.typed = 1'b0;
    v.re = '0;
    v.im = '0;
    v.st = ST_OK;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Output side. The stall pattern switches at random between none, random
  // and periodic; once, after HOLD_AT input transactions, the output is held
  // off in one long hold-off so that the pipeline fills and stalls input.
  // --------------------------------------------------------------------------
  initial begin
    int  cyc;
    int  mode;
    bit  held;
    cyc = 0;
    mode = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && accepted >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      cyc++;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 35);
        default: out_stall <= (cyc % 3 == 0);
      endcase
    end
  end

  // Each completed output transaction is checked against the oldest entry.
  always @(posedge clk) begin
    cplx_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expected result waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_res_real !== exp_r.re) begin
          $error("res_real: expected %h, actual %h", exp_r.re, out_res_real);
          errors++;
        end
        if (out_res_imag !== exp_r.im) begin
          $error("res_imag: expected %h, actual %h", exp_r.im, out_res_imag);
          errors++;
        end
        if (out_status !== exp_r.st) begin
          $error("status: expected %0d, actual %0d", exp_r.st, out_status);
          errors++;
        end
      end
    end
  end

  // The watchdog counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random bursts, drain.
  // --------------------------------------------------------------------------
  initial begin
    vector_t directed[];
    vector_t v;
    int      left;
    int      burst;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = '0;
    in_a_real = '0;
    in_a_imag = '0;
    in_b_real = '0;
    in_b_imag = '0;

    // Rows with typed set carry a result that is plain from the operands:
    // zero and clamped sums, zero divisors, conjugates of extremes, an exact and
    // a clamped magnitude and spare opcodes. The rest go through the predictor.
    directed = '{
      '{OP_ADD,  32'h0, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, ST_OK},
      '{OP_ADD,  32'h7fffffff, 32'h7fffffff, 32'h1, 32'h1, 1,
        32'h7fffffff, 32'h7fffffff, ST_SAT},
      '{OP_SUB,  32'h80000000, 32'h80000000, 32'h1, 32'h1, 1,
        32'h80000000, 32'h80000000, ST_SAT},
      '{OP_MUL,  32'h10000, 32'h0, 32'h10000, 32'h0, 0, 32'h0, 32'h0, ST_OK},
      '{OP_MUL,  32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0,
        32'h0, 32'h0, ST_OK},
      '{OP_MUL,  32'h1, 32'h0, 32'h8000, 32'h0, 0, 32'h0, 32'h0, ST_OK},
      '{OP_MUL,  32'hffffffff, 32'h0, 32'h8000, 32'h0, 0, 32'h0, 32'h0, ST_OK},
      '{OP_DIV,  32'h10000, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, ST_DZ},
      '{OP_DIV,  32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 1, 32'h0, 32'h0, ST_DZ},
      '{OP_DIV,  32'h7fffffff, 32'h0, 32'h1, 32'h0, 0, 32'h0, 32'h0, ST_OK},
      '{OP_DIV,  32'h30000, 32'h10000, 32'h10000, 32'hffff0000, 0,
        32'h0, 32'h0, ST_OK},
      '{OP_DIV,  32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0,
        32'h0, 32'h0, ST_OK},
      '{OP_CONJ, 32'h1234, 32'h80000000, 32'h0, 32'h0, 1,
        32'h1234, 32'h7fffffff, ST_SAT},
      '{OP_CONJ, 32'h80000000, 32'h7fffffff, 32'h5, 32'h5, 1,
        32'h80000000, 32'h80000001, ST_OK},
      '{OP_MAG,  32'h30000, 32'h40000, 32'h0, 32'h0, 1, 32'h50000, 32'h0, ST_OK},
      '{OP_MAG,  32'h80000000, 32'h80000000, 32'h0, 32'h0, 1,
        32'h7fffffff, 32'h0, ST_SAT},
      '{OP_MAG,  32'hffffffff, 32'h0, 32'h0, 32'h0, 0, 32'h0, 32'h0, ST_OK},
      '{OP_MAG,  32'h1, 32'h1, 32'h0, 32'h0, 0, 32'h0, 32'h0, ST_OK},
      '{OP_SPARE6, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1, 1,
        32'h0, 32'h0, ST_OK},
      '{OP_SPARE7, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff, 1,
        32'h0, 32'h0, ST_OK}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_item(directed[i]);
    pause_input($urandom_range(1, 4));

    // Random part in bursts of 1..40 transactions, each followed by an idle gap,
    // and every so often a long burst with no gap at all.
    left = RANDOM_ITEMS;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) begin
        v = random_item();
        send_item(v);
      end
      left -= burst;
      pause_input($urandom_range(1, 8));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/cau_pkg.sv
design/complex_arithmetic_unit.sv
design/cau_checker.sv
sim/complex_arithmetic_unit_tb.sv
